/* sv/rqh_pkg.sv */
`default_nettype none

package rqh_pkg;

  // Default build sizes.
  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int QUALITY_BINS_DEF  = 128;
  localparam int COUNT_BITS_DEF    = 40;

  // Fixed alphabet and field widths.
  localparam int NUM_BASES     = 5;
  localparam int BT_BITS       = $clog2(NUM_BASES);
  localparam int ENTRY_BITS    = 40;
  localparam int TOTAL_BITS    = 48;
  localparam int LONGEST_BITS  = 11;
  localparam int QUAL_BITS     = 8;
  localparam int CODE_BITS     = 3;
  localparam int PIDX_BITS     = 11;
  localparam int BIN_BITS      = 8;
  localparam int KIND_BITS     = 2;
  localparam int TABLE_BITS    = 3;

  // Stream widths.
  localparam int IN_TDATA_BITS  = 32;
  localparam int IN_TUSER_BITS  = KIND_BITS + TABLE_BITS;
  localparam int OUT_TDATA_BITS = 152;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_BASE = 2'd0,
    KIND_END  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [TABLE_BITS-1:0] {
    TBL_BASE  = 3'd0,
    TBL_QUAL  = 3'd1,
    TBL_PBASE = 3'd2,
    TBL_PQUAL = 3'd3,
    TBL_LEN   = 3'd4
  } table_t;

  // Control of one histogram bank for the current cycle.
  typedef struct packed {
    logic clear;
    logic bump;
  } hist_ctl_t;

  // Running status carried with every result.
  typedef struct packed {
    logic                    overflow;
    logic [QUAL_BITS-1:0]    highest;
    logic [LONGEST_BITS-1:0] longest;
    logic [TOTAL_BITS-1:0]   total;
    logic [ENTRY_BITS-1:0]   reads;
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [ENTRY_BITS-1:0] entry;
  } result_t;

endpackage

`default_nettype wire

/* sv/rqh_ram.sv */
`default_nettype none

module rqh_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* sv/rqh_hist_bank.sv */
`default_nettype none

module rqh_hist_bank import rqh_pkg::*; #(
  parameter int DEPTH      = 5,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hist_ctl_t             ctl,
  input  wire logic [ADDR_BITS-1:0]  addr,
  output logic      [COUNT_BITS-1:0] count
);

  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;
  logic                  s1_bump;
  logic [ADDR_BITS-1:0]  s1_addr;
  logic                  fwd;
  logic [COUNT_BITS-1:0] fwd_val;
  logic                  we;
  logic [ADDR_BITS-1:0]  waddr;
  logic [COUNT_BITS-1:0] wdata;

  // The read issued last cycle may have missed the write of the beat ahead of it.
  assign cur   = fwd ? fwd_val : rdata;
  assign inc   = (cur == '1) ? cur : cur + COUNT_BITS'(1);
  assign count = cur;

  // Write port: clearing sweep or the write-back of last cycle's increment.
  assign we    = ctl.clear | s1_bump;
  assign waddr = ctl.clear ? addr : s1_addr;
  assign wdata = ctl.clear ? '0 : inc;

  rqh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  // Second stage of the read-modify-write, with the forwarding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_bump <= 1'b0;
      fwd     <= 1'b0;
    end else begin
      s1_bump <= ctl.bump;
      fwd     <= s1_bump && (s1_addr == addr);
    end
    s1_addr <= addr;
    fwd_val <= inc;
  end

endmodule

`default_nettype wire

/* sv/read_quality_histogram.sv */
// Read quality histogram: takes one beat per clock on the slave side (a base, an end of read,
// or a readout of one histogram entry) and returns exactly one result beat per input beat,
// in order, carrying the requested entry and the running read statistics. Each histogram is a
// single-port-read, single-port-write memory updated by read-modify-write over two stages, with
// forwarding between back-to-back beats to the same counter, so a new beat is taken every cycle
// while tready is high. A result passes through the update stage and then a four-entry result
// queue to the master side; the queue absorbs backpressure, and tready drops when that queue
// and the update stage together are full. After reset the block runs a clearing pass over all
// memories, one entry per cycle, over max(5*MAX_POSITIONS, QUALITY_BINS*MAX_POSITIONS,
// MAX_POSITIONS+1) entries (131072 by default) and accepts no beat until it is done.
`default_nettype none

module read_quality_histogram import rqh_pkg::*; #(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int QUALITY_BINS  = QUALITY_BINS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // base_code[2:0], quality[10:3], position_index[21:11], bin_index[29:22], zero[31:30]
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
  // kind[1:0], table_select[4:2]
  input  wire logic [IN_TUSER_BITS-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // entry_count[39:0], read_count[79:40], total_bases[127:80], longest_read[138:128],
  // highest_quality[146:139], overflow_flag[147], zero[151:148]
  output logic      [OUT_TDATA_BITS-1:0] m_tdata
);

  localparam int POS_BITS  = $clog2(MAX_POSITIONS + 1);
  localparam int QT_BITS   = $clog2(QUALITY_BINS);
  localparam int PB_DEPTH  = MAX_POSITIONS * NUM_BASES;
  localparam int PQ_DEPTH  = MAX_POSITIONS * QUALITY_BINS;
  localparam int LEN_DEPTH = MAX_POSITIONS + 1;
  localparam int PB_BITS   = $clog2(PB_DEPTH);
  localparam int PQ_BITS   = $clog2(PQ_DEPTH);
  localparam int CLR_LEN0  = (PB_DEPTH > PQ_DEPTH) ? PB_DEPTH : PQ_DEPTH;
  localparam int CLR_LEN   = (CLR_LEN0 > LEN_DEPTH) ? CLR_LEN0 : LEN_DEPTH;
  localparam int CLR_BITS  = $clog2(CLR_LEN);
  localparam int PW        = ((POS_BITS > PIDX_BITS) ? POS_BITS : PIDX_BITS) + 1;
  localparam int OUT_DEPTH = 4;
  localparam int PTR_BITS  = $clog2(OUT_DEPTH);
  localparam int CNT_BITS  = $clog2(OUT_DEPTH + 1);
  localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(MAX_POSITIONS);

  // Input beat fields.
  kind_t                kind;
  table_t               table_sel;
  logic [CODE_BITS-1:0] base_code;
  logic [QUAL_BITS-1:0] quality;
  logic [PIDX_BITS-1:0] position_index;
  logic [BIN_BITS-1:0]  bin_index;

  assign kind           = kind_t'(s_tuser[KIND_BITS-1:0]);
  assign table_sel      = table_t'(s_tuser[IN_TUSER_BITS-1:KIND_BITS]);
  assign base_code      = s_tdata[2:0];
  assign quality        = s_tdata[10:3];
  assign position_index = s_tdata[21:11];
  assign bin_index      = s_tdata[29:22];

  // Running state.
  logic [POS_BITS-1:0]   cur_pos;
  logic [COUNT_BITS-1:0] reads_done;
  logic [TOTAL_BITS-1:0] bases_done;
  logic [POS_BITS-1:0]   max_len;
  logic [QUAL_BITS-1:0]  max_qual;
  logic                  overflow;
  logic [POS_BITS-1:0]   cur_pos_next;
  logic [COUNT_BITS-1:0] reads_done_next;
  logic [TOTAL_BITS-1:0] bases_done_next;
  logic [POS_BITS-1:0]   max_len_next;
  logic [QUAL_BITS-1:0]  max_qual_next;
  logic                  overflow_next;
  logic [TOTAL_BITS:0]   bases_sum;

  logic accept;
  logic is_base;
  logic is_end;
  logic is_read;
  logic pos_ok;
  logic code_ok;
  logic qual_ok;
  logic bin_base_ok;
  logic bin_qual_ok;
  logic pidx_ok;
  logic len_ok;
  logic read_hit;
  logic base_bump;
  logic qual_bump;

  // Clearing pass.
  logic                clearing;
  logic [CLR_BITS-1:0] clr_cnt;

  // Update stage and result queue.
  logic                  s1_valid;
  logic                  s1_hit;
  table_t                s1_table;
  status_t               s1_status;
  status_t               status_next;
  logic [COUNT_BITS-1:0] entry_full;
  result_t               s1_result;
  result_t               queue [OUT_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   q_count;
  logic [CNT_BITS-1:0]   occupancy;
  logic                  pop;

  // Bank addresses and controls.
  logic [BT_BITS-1:0]    bt_addr;
  logic [QT_BITS-1:0]    qt_addr;
  logic [POS_BITS-1:0]   pos_sel;
  logic [BT_BITS-1:0]    b_sel;
  logic [QUAL_BITS-1:0]  q_sel;
  logic [PB_BITS-1:0]    pb_addr;
  logic [PQ_BITS-1:0]    pq_addr;
  logic [POS_BITS-1:0]   len_addr;
  hist_ctl_t             bt_ctl;
  hist_ctl_t             qt_ctl;
  hist_ctl_t             pb_ctl;
  hist_ctl_t             pq_ctl;
  hist_ctl_t             len_ctl;
  logic [COUNT_BITS-1:0] bt_count;
  logic [COUNT_BITS-1:0] qt_count;
  logic [COUNT_BITS-1:0] pb_count;
  logic [COUNT_BITS-1:0] pq_count;
  logic [COUNT_BITS-1:0] len_count;

  // Handshake: room for the beat in flight plus the one being taken.
  assign occupancy = q_count + CNT_BITS'(s1_valid);
  assign s_tready  = !clearing && (occupancy < CNT_BITS'(OUT_DEPTH));
  assign accept    = s_tvalid && s_tready;
  assign is_base   = accept && (kind == KIND_BASE);
  assign is_end    = accept && (kind == KIND_END);
  assign is_read   = accept && (kind == KIND_READ);

  // Range checks.
  assign pos_ok      = cur_pos < POS_LIMIT;
  assign code_ok     = base_code < CODE_BITS'(NUM_BASES);
  assign qual_ok     = {1'b0, quality} < (QUAL_BITS + 1)'(QUALITY_BINS);
  assign bin_base_ok = bin_index < BIN_BITS'(NUM_BASES);
  assign bin_qual_ok = {1'b0, bin_index} < (BIN_BITS + 1)'(QUALITY_BINS);
  assign pidx_ok     = PW'(position_index) < PW'(MAX_POSITIONS);
  assign len_ok      = PW'(position_index) <= PW'(MAX_POSITIONS);
  assign base_bump   = is_base && pos_ok && code_ok;
  assign qual_bump   = is_base && pos_ok && qual_ok;

  // Readout validity for the selected table.
  always_comb begin
    case (table_sel)
      TBL_BASE:  read_hit = bin_base_ok;
      TBL_QUAL:  read_hit = bin_qual_ok;
      TBL_PBASE: read_hit = pidx_ok && bin_base_ok;
      TBL_PQUAL: read_hit = pidx_ok && bin_qual_ok;
      TBL_LEN:   read_hit = len_ok;
      default:   read_hit = 1'b0;
    endcase
  end

  // Counter addresses: the current base, the current read length at an end of read, or the readout coordinates.
  always_comb begin
    if (kind == KIND_BASE) begin
      pos_sel = cur_pos;
      b_sel   = BT_BITS'(base_code);
      q_sel   = quality;
    end else begin
      pos_sel = POS_BITS'(position_index);
      b_sel   = BT_BITS'(bin_index);
      q_sel   = bin_index;
    end
    bt_addr  = b_sel;
    qt_addr  = QT_BITS'(q_sel);
    pb_addr  = PB_BITS'(pos_sel) * PB_BITS'(NUM_BASES) + PB_BITS'(b_sel);
    pq_addr  = PQ_BITS'(pos_sel) * PQ_BITS'(QUALITY_BINS) + PQ_BITS'(q_sel);
    len_addr = (kind == KIND_END) ? cur_pos : POS_BITS'(position_index);
  end

  // Bank controls: the clearing sweep touches each bank only inside its depth.
  assign bt_ctl.clear  = clearing && (32'(clr_cnt) < 32'(NUM_BASES));
  assign bt_ctl.bump   = base_bump;
  assign qt_ctl.clear  = clearing && (32'(clr_cnt) < 32'(QUALITY_BINS));
  assign qt_ctl.bump   = qual_bump;
  assign pb_ctl.clear  = clearing && (32'(clr_cnt) < 32'(PB_DEPTH));
  assign pb_ctl.bump   = base_bump;
  assign pq_ctl.clear  = clearing && (32'(clr_cnt) < 32'(PQ_DEPTH));
  assign pq_ctl.bump   = qual_bump;
  assign len_ctl.clear = clearing && (32'(clr_cnt) < 32'(LEN_DEPTH));
  assign len_ctl.bump  = is_end;

  rqh_hist_bank #(
    .DEPTH      (NUM_BASES),
    .COUNT_BITS (COUNT_BITS)
  ) u_base_totals (
    .clk   (clk),
    .rst   (rst),
    .ctl   (bt_ctl),
    .addr  (clearing ? clr_cnt[BT_BITS-1:0] : bt_addr),
    .count (bt_count)
  );

  rqh_hist_bank #(
    .DEPTH      (QUALITY_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_quality_totals (
    .clk   (clk),
    .rst   (rst),
    .ctl   (qt_ctl),
    .addr  (clearing ? clr_cnt[QT_BITS-1:0] : qt_addr),
    .count (qt_count)
  );

  rqh_hist_bank #(
    .DEPTH      (PB_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_position_base (
    .clk   (clk),
    .rst   (rst),
    .ctl   (pb_ctl),
    .addr  (clearing ? clr_cnt[PB_BITS-1:0] : pb_addr),
    .count (pb_count)
  );

  rqh_hist_bank #(
    .DEPTH      (PQ_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_position_quality (
    .clk   (clk),
    .rst   (rst),
    .ctl   (pq_ctl),
    .addr  (clearing ? clr_cnt[PQ_BITS-1:0] : pq_addr),
    .count (pq_count)
  );

  rqh_hist_bank #(
    .DEPTH      (LEN_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_lengths (
    .clk   (clk),
    .rst   (rst),
    .ctl   (len_ctl),
    .addr  (clearing ? clr_cnt[POS_BITS-1:0] : len_addr),
    .count (len_count)
  );

  // Next values of the running statistics.
  assign bases_sum = {1'b0, bases_done} + (TOTAL_BITS + 1)'(cur_pos);

  always_comb begin
    cur_pos_next    = cur_pos;
    reads_done_next = reads_done;
    bases_done_next = bases_done;
    max_len_next    = max_len;
    max_qual_next   = max_qual;
    overflow_next   = overflow;
    if (is_base) begin
      if (!pos_ok) begin
        overflow_next = 1'b1;
      end else begin
        if (!code_ok) begin
          overflow_next = 1'b1;
        end
        if (!qual_ok) begin
          overflow_next = 1'b1;
        end else if (quality > max_qual) begin
          max_qual_next = quality;
        end
        cur_pos_next = cur_pos + POS_BITS'(1);
      end
    end
    if (is_end) begin
      if (reads_done != '1) begin
        reads_done_next = reads_done + COUNT_BITS'(1);
      end
      bases_done_next = bases_sum[TOTAL_BITS] ? '1 : bases_sum[TOTAL_BITS-1:0];
      if (cur_pos > max_len) begin
        max_len_next = cur_pos;
      end
      cur_pos_next = '0;
    end
  end

  assign status_next.overflow = overflow_next;
  assign status_next.highest  = max_qual_next;
  assign status_next.longest  = LONGEST_BITS'(max_len_next);
  assign status_next.total    = bases_done_next;
  assign status_next.reads    = ENTRY_BITS'(reads_done_next);

  // Running statistics and clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pos    <= '0;
      reads_done <= '0;
      bases_done <= '0;
      max_len    <= '0;
      max_qual   <= '0;
      overflow   <= 1'b0;
      clearing   <= 1'b1;
      clr_cnt    <= '0;
    end else begin
      cur_pos    <= cur_pos_next;
      reads_done <= reads_done_next;
      bases_done <= bases_done_next;
      max_len    <= max_len_next;
      max_qual   <= max_qual_next;
      overflow   <= overflow_next;
      if (clearing) begin
        if (clr_cnt == CLR_BITS'(CLR_LEN - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_cnt <= clr_cnt + CLR_BITS'(1);
        end
      end
    end
  end

  // Update stage: the banks return their counts in the cycle after the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_hit    <= is_read && read_hit;
    s1_table  <= table_sel;
    s1_status <= status_next;
  end

  always_comb begin
    case (s1_table)
      TBL_BASE:  entry_full = bt_count;
      TBL_QUAL:  entry_full = qt_count;
      TBL_PBASE: entry_full = pb_count;
      TBL_PQUAL: entry_full = pq_count;
      TBL_LEN:   entry_full = len_count;
      default:   entry_full = '0;
    endcase
  end

  assign s1_result.status = s1_status;
  assign s1_result.entry  = s1_hit ? ENTRY_BITS'(entry_full) : '0;

  // Result queue between the update stage and the master side.
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (q_count != '0);
  assign m_tdata  = {(OUT_TDATA_BITS - $bits(result_t))'(0), queue[rd_ptr]};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      q_count <= q_count + CNT_BITS'(s1_valid) - CNT_BITS'(pop);
    end
    if (s1_valid) begin
      queue[wr_ptr] <= s1_result;
    end
  end

`ifndef NO_ASSERTIONS
  // No beat is taken while the memories are being cleared.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    accept |-> !clearing)
    else $error("beat accepted during clearing pass");

  // The queue plus the update stage never hold more results than the queue can store.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_BITS'(OUT_DEPTH))
    else $error("result queue overrun");

  // Every accepted beat reaches the update stage in the next cycle.
  a_beat_to_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat lost before update stage");

  // The overflow flag never clears outside reset.
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("overflow flag cleared");

  // The read position never passes the built limit.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    cur_pos <= POS_LIMIT)
    else $error("read position beyond limit");
`endif

endmodule

`default_nettype wire

/* dv/read_quality_histogram_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the read quality histogram, keeps its own copy of every histogram
// and running total, and compares each result beat with the oldest predicted result.
module read_quality_histogram_checker import rqh_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  input  wire logic                      s_tready,
  // base_code, quality, position_index, bin_index, zero
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
  // kind, table_select
  input  wire logic [IN_TUSER_BITS-1:0]  s_tuser,
  input  wire logic                      m_tvalid,
  input  wire logic                      m_tready,
  // entry_count, read_count, total_bases, longest_read, highest_quality, overflow_flag, zero
  input  wire logic [OUT_TDATA_BITS-1:0] m_tdata,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int POSITIONS = MAX_POSITIONS_DEF;
  localparam int BINS      = QUALITY_BINS_DEF;

  typedef logic [COUNT_BITS_DEF-1:0] count_t;

  localparam count_t                COUNT_TOP = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_TOP = '1;

  // Shadow histograms and running status.
  count_t                base_tot  [NUM_BASES];
  count_t                qual_tot  [BINS];
  count_t                pos_base  [POSITIONS*NUM_BASES];
  count_t                pos_qual  [POSITIONS*BINS];
  count_t                len_hist  [POSITIONS+1];
  int unsigned           cur_pos;
  count_t                reads_seen;
  logic [TOTAL_BITS-1:0] bases_seen;
  int unsigned           longest_seen;
  logic [QUAL_BITS-1:0]  top_qual;
  logic                  ovf_seen;

  result_t               pending_results[$];
  int                    miss_count;
  int                    result_index;

  function automatic count_t sat_inc(count_t c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  function automatic void clear_state();
    foreach (base_tot[i]) base_tot[i] = '0;
    foreach (qual_tot[i]) qual_tot[i] = '0;
    foreach (pos_base[i]) pos_base[i] = '0;
    foreach (pos_qual[i]) pos_qual[i] = '0;
    foreach (len_hist[i]) len_hist[i] = '0;
    cur_pos      = 0;
    reads_seen   = '0;
    bases_seen   = '0;
    longest_seen = 0;
    top_qual     = '0;
    ovf_seen     = 1'b0;
  endfunction

  // One base of the current read: bases past the position limit are dropped entirely,
  // an unknown base code skips only the base tables, a high quality only the quality tables.
  function automatic void count_base(int unsigned code, int unsigned qual);
    int unsigned p;
    p = cur_pos;
    if (p >= POSITIONS) begin
      ovf_seen = 1'b1;
    end else begin
      if (code < NUM_BASES) begin
        base_tot[code]               = sat_inc(base_tot[code]);
        pos_base[p*NUM_BASES + code] = sat_inc(pos_base[p*NUM_BASES + code]);
      end else begin
        ovf_seen = 1'b1;
      end
      if (qual < BINS) begin
        qual_tot[qual]          = sat_inc(qual_tot[qual]);
        pos_qual[p*BINS + qual] = sat_inc(pos_qual[p*BINS + qual]);
        if (qual > top_qual) top_qual = qual[QUAL_BITS-1:0];
      end else begin
        ovf_seen = 1'b1;
      end
      cur_pos = p + 1;
    end
  endfunction

  // End of read: the length is capped at the position limit before it is filed.
  function automatic void close_read();
    int unsigned len;
    len = (cur_pos > POSITIONS) ? POSITIONS : cur_pos;
    reads_seen    = sat_inc(reads_seen);
    len_hist[len] = sat_inc(len_hist[len]);
    if (TOTAL_TOP - bases_seen < len) bases_seen = TOTAL_TOP;
    else bases_seen = bases_seen + len;
    if (len > longest_seen) longest_seen = len;
    cur_pos = 0;
  endfunction

  // Readout of one entry; anything outside the selected table reads as zero.
  function automatic count_t lookup_entry(logic [TABLE_BITS-1:0] tbl, int unsigned pos,
                                          int unsigned bin);
    case (tbl)
      TBL_BASE: begin
        if (bin < NUM_BASES) return base_tot[bin];
      end
      TBL_QUAL: begin
        if (bin < BINS) return qual_tot[bin];
      end
      TBL_PBASE: begin
        if (pos < POSITIONS && bin < NUM_BASES) return pos_base[pos*NUM_BASES + bin];
      end
      TBL_PQUAL: begin
        if (pos < POSITIONS && bin < BINS) return pos_qual[pos*BINS + bin];
      end
      TBL_LEN: begin
        if (pos <= POSITIONS) return len_hist[pos];
      end
      default: ;
    endcase
    return '0;
  endfunction

  // Applies one accepted input beat to the shadow state and returns the result it causes.
  function automatic result_t apply_beat(logic [IN_TUSER_BITS-1:0] user,
                                         logic [IN_TDATA_BITS-1:0] data);
    result_t r;
    r = '0;
    case (user[KIND_BITS-1:0])
      KIND_BASE: count_base(data[2:0], data[10:3]);
      KIND_END:  close_read();
      KIND_READ: r.entry = lookup_entry(user[4:2], data[21:11], data[29:22]);
      default: ;
    endcase
    r.status.reads    = reads_seen;
    r.status.total    = bases_seen;
    r.status.longest  = longest_seen[LONGEST_BITS-1:0];
    r.status.highest  = top_qual;
    r.status.overflow = ovf_seen;
    return r;
  endfunction

  task automatic flag_miss(string field, logic [63:0] want, logic [63:0] got);
    miss_count++;
    if (miss_count <= 10)
      $display("%0t: result %0d %s expected 0x%0h got 0x%0h", $realtime, result_index, field,
               want, got);
  endtask

  // Predict on every accepted input beat, compare on every accepted result beat.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      clear_state();
      pending_results.delete();
    end else begin
      if (s_tvalid && s_tready) pending_results.push_back(apply_beat(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("%0t: result beat 0x%0h arrived with nothing expected", $realtime, m_tdata);
        end else begin
          want = pending_results.pop_front();
          got  = m_tdata[$bits(result_t)-1:0];
          if (got.entry !== want.entry)
            flag_miss("entry_count", want.entry, got.entry);
          if (got.status.reads !== want.status.reads)
            flag_miss("read_count", want.status.reads, got.status.reads);
          if (got.status.total !== want.status.total)
            flag_miss("total_bases", want.status.total, got.status.total);
          if (got.status.longest !== want.status.longest)
            flag_miss("longest_read", want.status.longest, got.status.longest);
          if (got.status.highest !== want.status.highest)
            flag_miss("highest_quality", want.status.highest, got.status.highest);
          if (got.status.overflow !== want.status.overflow)
            flag_miss("overflow_flag", want.status.overflow, got.status.overflow);
        end
        result_index++;
      end
    end
    mismatches  <= miss_count;
    outstanding <= pending_results.size();
  end

endmodule

/* dv/read_quality_histogram_test.sv */
`timescale 1ns / 1ps

// Drives base, end-of-read and readout beats into the read quality histogram with random
// idling on both sides and gives the verdict from the checker's mismatch count.
module read_quality_histogram_test;
  import rqh_pkg::*;

  localparam int POSITIONS    = MAX_POSITIONS_DEF;
  localparam int BINS         = QUALITY_BINS_DEF;
  localparam int BEAT_GOAL    = 1950;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 250;

  // Codes outside the package enums.
  localparam logic [KIND_BITS-1:0]  KIND_SPARE    = 2'd3;
  localparam logic [TABLE_BITS-1:0] TBL_UNUSED_LO = 3'd5;
  localparam logic [TABLE_BITS-1:0] TBL_UNUSED_HI = 3'd7;
  localparam logic [CODE_BITS-1:0]  BASE_A        = 3'd0;
  localparam logic [CODE_BITS-1:0]  BASE_G        = 3'd2;
  localparam logic [CODE_BITS-1:0]  BASE_T        = 3'd3;
  localparam logic [CODE_BITS-1:0]  BASE_N        = 3'd4;
  localparam logic [CODE_BITS-1:0]  BASE_BAD_HI   = 3'd7;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
  logic [IN_TUSER_BITS-1:0]  s_tuser  = '0;
  logic                      m_tready = 1'b0;
  wire logic                 s_tready;
  wire logic                 m_tvalid;
  wire logic [OUT_TDATA_BITS-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int beats_sent  = 0;
  int cycle_count = 0;
  bit steady      = 1'b0;

  read_quality_histogram i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  read_quality_histogram_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("read_quality_histogram verification failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off so the block backs up into its input.
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && beats_sent >= 300) begin
        m_tready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        held_off = 1'b1;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 22);
        @(posedge clk);
      end
    end
  end

  // Offers one beat after a random gap and waits until it is taken.
  task automatic send_beat(logic [KIND_BITS-1:0] kind, logic [CODE_BITS-1:0] code,
                           logic [QUAL_BITS-1:0] qual, logic [TABLE_BITS-1:0] tbl,
                           logic [PIDX_BITS-1:0] pos, logic [BIN_BITS-1:0] bin);
    while (!steady && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, bin, pos, qual, code};
    s_tuser  <= {tbl, kind};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    steady = (beats_sent >= 1000 && beats_sent < 1300);
  endtask

  // Fields a beat does not use carry random values.
  task automatic send_base(logic [CODE_BITS-1:0] code, logic [QUAL_BITS-1:0] qual);
    send_beat(KIND_BASE, code, qual, TABLE_BITS'($urandom), PIDX_BITS'($urandom),
              BIN_BITS'($urandom));
  endtask

  task automatic send_end();
    send_beat(KIND_END, CODE_BITS'($urandom), QUAL_BITS'($urandom), TABLE_BITS'($urandom),
              PIDX_BITS'($urandom), BIN_BITS'($urandom));
  endtask

  task automatic send_read_out(logic [TABLE_BITS-1:0] tbl, logic [PIDX_BITS-1:0] pos,
                               logic [BIN_BITS-1:0] bin);
    send_beat(KIND_READ, CODE_BITS'($urandom), QUAL_BITS'($urandom), tbl, pos, bin);
  endtask

  function automatic logic [CODE_BITS-1:0] rand_code();
    if ($urandom_range(99) < 90) return CODE_BITS'($urandom_range(BASE_N));
    return CODE_BITS'($urandom_range(BASE_BAD_HI, BASE_N + 1));
  endfunction

  // Qualities cluster in a narrow band so readouts find nonzero entries.
  function automatic logic [QUAL_BITS-1:0] rand_qual();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return QUAL_BITS'($urandom_range(41, 30));
    if (pick < 90) return QUAL_BITS'($urandom_range(BINS - 1));
    return QUAL_BITS'($urandom_range(255, BINS));
  endfunction

  // Readout aimed mostly at populated entries, with some out-of-range probes.
  task automatic random_readout();
    logic [TABLE_BITS-1:0] tbl;
    logic [PIDX_BITS-1:0]  pos;
    logic [BIN_BITS-1:0]   bin;
    int                    pick;
    if ($urandom_range(99) < 88) tbl = TABLE_BITS'($urandom_range(TBL_LEN));
    else tbl = TABLE_BITS'($urandom_range(TBL_UNUSED_HI, TBL_UNUSED_LO));
    pick = $urandom_range(99);
    if (pick < 55) pos = PIDX_BITS'($urandom_range(24));
    else if (pick < 75) pos = PIDX_BITS'($urandom_range(POSITIONS, POSITIONS - 6));
    else pos = PIDX_BITS'($urandom_range(11'h7FF));
    pick = $urandom_range(99);
    if (pick < 45) bin = BIN_BITS'($urandom_range(BASE_N));
    else if (pick < 75) bin = BIN_BITS'($urandom_range(41, 30));
    else if (pick < 90) bin = BIN_BITS'($urandom_range(BINS - 1));
    else bin = BIN_BITS'($urandom_range(255));
    send_read_out(tbl, pos, bin);
  endtask

  initial begin : stimulus
    int  extra;
    int  long_at;
    bit  long_done;
    int  len;
    int  pick;

    // Nothing is offered until reset has been released.
    do @(posedge clk); while (rst);

    // Directed: field extremes, each kind and the corner cases.
    send_read_out(TBL_BASE, 0, BIN_BITS'(BASE_A));
    send_base(BASE_A, 0);
    send_base(BASE_N, QUAL_BITS'(BINS - 1));
    send_base(BASE_BAD_HI, 40);           // unknown base, quality still counted
    send_base(BASE_G, QUAL_BITS'(BINS));  // quality just past the bins
    send_base(BASE_T, 255);
    send_end();
    send_end();                           // read with no bases
    send_read_out(TBL_BASE, 0, BIN_BITS'(BASE_N));
    send_read_out(TBL_BASE, 0, BIN_BITS'(BASE_N + 1));
    send_read_out(TBL_QUAL, 0, BIN_BITS'(BINS - 1));
    send_read_out(TBL_QUAL, 0, 40);
    send_read_out(TBL_QUAL, 0, BIN_BITS'(BINS));
    send_read_out(TBL_PBASE, 1, BIN_BITS'(BASE_N));
    send_read_out(TBL_PBASE, PIDX_BITS'(POSITIONS), BIN_BITS'(BASE_A));
    send_read_out(TBL_PQUAL, 0, 0);
    send_read_out(TBL_PQUAL, 11'h7FF, 8'hFF);
    send_read_out(TBL_LEN, 5, 8'hFF);     // bin is ignored for lengths
    send_read_out(TBL_LEN, 0, 0);
    send_read_out(TBL_LEN, PIDX_BITS'(POSITIONS), 0);
    send_read_out(TBL_LEN, 11'h7FF, 0);
    send_read_out(TBL_UNUSED_LO, 0, 0);
    send_read_out(TBL_UNUSED_HI, 1, 1);
    send_beat(KIND_SPARE, '1, '1, '1, '1, '1);

    // Random: mostly whole reads, with readouts, spare kinds and stray bases mixed in.
    long_at   = $urandom_range(900, 200);
    long_done = 1'b0;
    while (beats_sent < BEAT_GOAL) begin
      if (!long_done && beats_sent >= long_at) begin
        // One read that runs past the position limit.
        extra = $urandom_range(6, 1);
        repeat (POSITIONS + extra) send_base(rand_code(), rand_qual());
        send_end();
        send_read_out(TBL_LEN, PIDX_BITS'(POSITIONS), BIN_BITS'($urandom));
        send_read_out(TBL_PBASE, PIDX_BITS'(POSITIONS - 1), BIN_BITS'($urandom_range(BASE_N)));
        send_read_out(TBL_PQUAL, PIDX_BITS'(POSITIONS - 1), BIN_BITS'($urandom_range(41, 30)));
        long_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
        repeat (len) begin
          if ($urandom_range(9) == 0) random_readout();
          send_base(rand_code(), rand_qual());
        end
        send_end();
      end else if (pick < 90) begin
        random_readout();
      end else if (pick < 95) begin
        send_beat(KIND_SPARE, CODE_BITS'($urandom), QUAL_BITS'($urandom),
                  TABLE_BITS'($urandom), PIDX_BITS'($urandom), BIN_BITS'($urandom));
      end else begin
        send_base(rand_code(), rand_qual());
      end
    end

    // Drain and verdict.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("read_quality_histogram verification clean");
    end else begin
      $display("read_quality_histogram verification failed");
    end
    $finish;
  end

endmodule
